>>> rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants of the sequence gap monitor.
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int CHANNEL_SLOTS = 256;
    localparam int SLOT_W        = 8;
    localparam int RESULTS       = 4;

    localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_MODULUS = 2'd0;
    localparam logic [1:0] CFG_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_VOTES   = 2'd2;

    // result positions inside one item's group, in delivery order
    localparam int POS_PACKET   = 0;
    localparam int POS_CHANNEL  = 1;
    localparam int POS_ACCEPTED = 2;
    localparam int POS_ACC_GAP  = 3;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_PACKET   = 2'd1,
        KIND_CHANNEL  = 2'd2,
        KIND_ACC_GAP  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [47:0] time_stamp;
        logic [7:0]  channel_address;
        logic [30:0] accepted_id;
        logic [30:0] channel_id;
        logic [31:0] packet_number;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  result_channel;
        logic [39:0] range_first;
        logic [39:0] range_last;
        logic [47:0] event_time;
        logic        last_result;
    } out_item_t;

    // per-slot record held in the slot memory
    typedef struct packed {
        logic        rolling;
        logic [7:0]  votes;
        logic [15:0] total;
        logic [30:0] cid0;
        logic [30:0] cid1;
        logic [47:0] t0;
        logic [47:0] t1;
        logic [39:0] a0;
        logic [39:0] a1;
    } slot_entry_t;

    // results produced by one transaction, handed to the sequencer
    typedef struct packed {
        logic [RESULTS-1:0]              mask;
        out_item_t [RESULTS-1:0]         res;
    } result_group_t;

endpackage

>>> rtl/sgm_slot_mem.sv
// ----------------------------------------------------------------------------
// sgm_slot_mem
// Per-slot record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sgm_slot_mem (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [sgm_pkg::SLOT_W-1:0] rd_addr,
    output sgm_pkg::slot_entry_t       rd_data,
    input  logic                       wr_en,
    input  logic [sgm_pkg::SLOT_W-1:0] wr_addr,
    input  sgm_pkg::slot_entry_t       wr_data
);
    import sgm_pkg::*;

    slot_entry_t mem [CHANNEL_SLOTS];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sgm_result_seq.sv
// ----------------------------------------------------------------------------
// sgm_result_seq
// Holds the result group of one transaction and hands results out in order.
// ----------------------------------------------------------------------------
module sgm_result_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  sgm_pkg::result_group_t grp,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sgm_pkg::out_item_t     out_data
);
    import sgm_pkg::*;

    logic [RESULTS-1:0]      mask_reg;
    logic [RESULTS-1:0]      mask_next;
    out_item_t [RESULTS-1:0] res_reg;
    logic [RESULTS-1:0]      pick;
    logic [RESULTS-1:0]      rest;
    logic                    found;

    // lowest pending result goes first
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < RESULTS; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                pick[i] = 1'b1;
                found   = 1'b1;
            end
        end
    end

    assign rest      = mask_reg & ~pick;
    assign out_valid = |mask_reg;
    assign can_load  = (rest == '0) && (!out_valid || out_ready);

    always_comb
    begin
        out_data = '0;
        for (int i = 0; i < RESULTS; i++)
        begin
            if (pick[i])
            begin
                out_data = res_reg[i];
            end
        end
        out_data.last_result = (rest == '0);
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (out_valid && out_ready)
        begin
            mask_next = rest;
        end
        if (load)
        begin
            mask_next = grp.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= grp.res;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (mask_reg == '0 || (out_ready && $countones(mask_reg) == 1)))
        else $error("result group loaded over pending results");

    a_record_present: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> grp.mask[POS_ACCEPTED])
        else $error("transaction without accepted record");

    a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !load) |=>
            ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("sequencer did not retire exactly one result");

endmodule

>>> rtl/sequence_gap_monitor.sv
// ----------------------------------------------------------------------------
// sequence_gap_monitor
// Fragment stream monitor: accepted-id extension and gap range reporting.
// ----------------------------------------------------------------------------
// Each fragment transaction produces one to four result transactions, in the
// order lost packets, lost channel ids, accepted record, lost accepted ids;
// the final one carries last_result. Per-slot state (rollover phase, votes,
// rollover count and the two-deep id/time/accepted histories) lives in a
// 256-entry memory with a registered read port; per-slot valid flops make
// untouched slots read as zero, so no clearing pass is needed after reset.
// Throughput is one fragment per cycle while each fragment yields a single
// result and out_ready is high; otherwise the result sequencer sets the pace at
// one result per cycle while out_ready is high. A fragment is held in stage 1,
// then its results in the sequencer. Configuration is written through
// cfg_we/cfg_index/cfg_data and must only change while the block is idle.
module sequence_gap_monitor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sgm_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sgm_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sgm_pkg::*;

    // configuration
    logic [31:0] modulus_reg;
    logic [30:0] window_reg;
    logic [7:0]  votes_cfg_reg;

    // stage 1: transaction waiting on its slot record
    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              s1_vbit_reg;
    logic              s1_adv;
    logic [SLOT_W-1:0] s1_slot;

    // forwarding of the most recent write
    logic              fwd_valid_reg;
    logic [SLOT_W-1:0] fwd_slot_reg;
    slot_entry_t       fwd_entry_reg;

    logic [CHANNEL_SLOTS-1:0] slot_valid_reg;

    // global packet history
    logic [31:0] pkt0_reg;
    logic [31:0] pkt1_reg;
    logic [47:0] pt0_reg;
    logic [47:0] pt1_reg;
    logic [31:0] pkt0_next;
    logic [31:0] pkt1_next;
    logic [47:0] pt0_next;
    logic [47:0] pt1_next;

    slot_entry_t   rd_entry;
    slot_entry_t   cur;
    slot_entry_t   upd;
    result_group_t grp;
    logic          can_load;
    logic          in_acc;

    // rollover / extension
    logic        near_wrap;
    logic        leave_zone;
    logic [7:0]  votes1;
    logic [32:0] raw_plus_win;
    logic [31:0] win2;
    logic [47:0] mul_prod;
    logic [48:0] acc_sum;
    logic [39:0] acc;
    logic [32:0] pkt_first;
    logic [31:0] c0p1;
    logic [40:0] a0p1;

    function automatic logic votes1_room();
        return cur.votes != 8'hFF;
    endfunction

    assign in_acc   = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && can_load;
    assign in_ready = !s1_valid_reg || can_load;
    assign s1_slot  = s1_item_reg.channel_address;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= 32'd65536;
            window_reg    <= 31'd1000;
            votes_cfg_reg <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODULUS: modulus_reg   <= cfg_data;
                CFG_WINDOW:  window_reg    <= cfg_data[30:0];
                CFG_VOTES:   votes_cfg_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sgm_slot_mem u_mem (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (in_data.channel_address),
        .rd_data (rd_entry),
        .wr_en   (s1_adv),
        .wr_addr (s1_slot),
        .wr_data (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            pkt0_reg       <= '0;
            pkt1_reg       <= '0;
            pt0_reg        <= '0;
            pt1_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                fwd_valid_reg           <= 1'b1;
                slot_valid_reg[s1_slot] <= 1'b1;
                pkt0_reg                <= pkt0_next;
                pkt1_reg                <= pkt1_next;
                pt0_reg                 <= pt0_next;
                pt1_reg                 <= pt1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg <= in_data;
            s1_vbit_reg <= slot_valid_reg[in_data.channel_address];
        end
        if (s1_adv)
        begin
            fwd_slot_reg  <= s1_slot;
            fwd_entry_reg <= upd;
        end
    end

    // record as of now: last write wins over a read that raced it
    always_comb
    begin
        if (fwd_valid_reg && fwd_slot_reg == s1_slot)
        begin
            cur = fwd_entry_reg;
        end
        else if (s1_vbit_reg)
        begin
            cur = rd_entry;
        end
        else
        begin
            cur = '0;
        end
    end

    // near-wrap test: raw > modulus - window, done without sign
    assign raw_plus_win = 33'(s1_item_reg.accepted_id) + 33'(window_reg);
    assign near_wrap    = !cur.rolling && (raw_plus_win > 33'(modulus_reg));
    assign leave_zone   = cur.rolling && (s1_item_reg.accepted_id > window_reg)
                          && (32'(s1_item_reg.accepted_id) < (modulus_reg >> 1));
    assign votes1 = ((near_wrap || leave_zone) && votes1_room()) ? cur.votes + 8'd1
                                                                 : cur.votes;
    assign win2 = {window_reg, 1'b0};

    always_comb
    begin
        upd         = cur;
        upd.votes   = votes1;
        if (votes1 > votes_cfg_reg)
        begin
            upd.rolling = !cur.rolling;
            upd.votes   = '0;
            if (cur.rolling && cur.total != 16'hFFFF)
            begin
                upd.total = cur.total + 16'd1;
            end
        end

        mul_prod = {32'd0, upd.total} * {16'd0, modulus_reg};
        acc_sum  = 49'(s1_item_reg.accepted_id) + 49'(mul_prod);
        if (upd.rolling && 32'(s1_item_reg.accepted_id) < win2)
        begin
            acc_sum = acc_sum + 49'(modulus_reg);
        end
        acc = (acc_sum > 49'(MAX40)) ? MAX40 : acc_sum[39:0];

        grp = '0;

        // network packets
        pkt0_next = pkt0_reg;
        pkt1_next = pkt1_reg;
        pt0_next  = pt0_reg;
        pt1_next  = pt1_reg;
        pkt_first = 33'(pkt0_reg) + 33'd1;
        if (s1_item_reg.packet_number != '0 && pkt0_reg != '0)
        begin
            if (pkt1_reg < s1_item_reg.packet_number)
            begin
                if (pkt_first < 33'(pkt1_reg))
                begin
                    grp.mask[POS_PACKET]                 = 1'b1;
                    grp.res[POS_PACKET].kind             = KIND_PACKET;
                    grp.res[POS_PACKET].range_first      = 40'(pkt_first);
                    grp.res[POS_PACKET].range_last       = 40'(pkt1_reg - 32'd1);
                    grp.res[POS_PACKET].event_time       = pt1_reg;
                end
                pkt0_next = pkt1_reg;
                pkt1_next = s1_item_reg.packet_number;
                pt0_next  = pt1_reg;
                pt1_next  = s1_item_reg.time_stamp;
            end
            else if (s1_item_reg.packet_number < pkt1_reg)
            begin
                pkt1_next = s1_item_reg.packet_number;
                pt1_next  = s1_item_reg.time_stamp;
            end
        end
        else if (s1_item_reg.packet_number != '0)
        begin
            pkt0_next = pkt1_reg;
            pkt1_next = s1_item_reg.packet_number;
            pt0_next  = pt1_reg;
            pt1_next  = s1_item_reg.time_stamp;
        end

        // channel ids
        c0p1 = 32'(cur.cid0) + 32'd1;
        if (cur.cid0 != '0)
        begin
            if (cur.cid0 < cur.cid1 && cur.cid1 < s1_item_reg.channel_id)
            begin
                if (c0p1 < 32'(cur.cid1))
                begin
                    grp.mask[POS_CHANNEL]               = 1'b1;
                    grp.res[POS_CHANNEL].kind           = KIND_CHANNEL;
                    grp.res[POS_CHANNEL].result_channel = s1_slot;
                    grp.res[POS_CHANNEL].range_first    = 40'(c0p1);
                    grp.res[POS_CHANNEL].range_last     = 40'(cur.cid1 - 31'd1);
                    grp.res[POS_CHANNEL].event_time     = cur.t1;
                end
                upd.t0   = cur.t1;
                upd.cid0 = cur.cid1;
            end
        end
        else
        begin
            upd.t0   = cur.t1;
            upd.cid0 = cur.cid1;
        end
        upd.t1   = s1_item_reg.time_stamp;
        upd.cid1 = s1_item_reg.channel_id;

        // accepted record
        grp.mask[POS_ACCEPTED]               = 1'b1;
        grp.res[POS_ACCEPTED].kind           = KIND_ACCEPTED;
        grp.res[POS_ACCEPTED].result_channel = s1_slot;
        grp.res[POS_ACCEPTED].range_first    = acc;
        grp.res[POS_ACCEPTED].range_last     = acc;
        grp.res[POS_ACCEPTED].event_time     = s1_item_reg.time_stamp;

        // accepted ids, guarded by the older timestamp
        a0p1 = 41'(cur.a0) + 41'd1;
        if (upd.t0 != '0)
        begin
            if (cur.a0 < cur.a1 && cur.a1 < acc)
            begin
                if (a0p1 < 41'(cur.a1))
                begin
                    grp.mask[POS_ACC_GAP]               = 1'b1;
                    grp.res[POS_ACC_GAP].kind           = KIND_ACC_GAP;
                    grp.res[POS_ACC_GAP].result_channel = s1_slot;
                    grp.res[POS_ACC_GAP].range_first    = a0p1[39:0];
                    grp.res[POS_ACC_GAP].range_last     = cur.a1 - 40'd1;
                    grp.res[POS_ACC_GAP].event_time     = s1_item_reg.time_stamp;
                end
                upd.a0 = cur.a1;
            end
            upd.a1 = acc;
        end
    end

    sgm_result_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv),
        .grp       (grp),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
